// File: sv/madt_pkg.sv
package madt_pkg;

   localparam int unsigned MAX_ENTRIES_DEFAULT = 8;
   localparam int unsigned DEADLINE_WIDTH      = 64;
   localparam int unsigned TPS_WIDTH           = 32;
   localparam logic [TPS_WIDTH-1:0] TPS_RESET  = 32'd10000000;
   localparam logic [DEADLINE_WIDTH-1:0] NO_DEADLINE = '1;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_DISABLE = 2'd1,
      KIND_SET     = 2'd2,
      KIND_SERVICE = 2'd3
   } kind_type;

endpackage

// File: sv/madt_ram.sv
module madt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 8,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/multi_alarm_deadline_table_unit.sv
// Path from request to result: clear and disable go straight to S_DONE, as does set on a
// full table; else set runs S_MUL (multiply) and S_ADD (add, table write). Service runs
// S_TEST at one RAM read a cycle, with S_MOVE moving the last entry into a freed slot (at
// most MAX_ENTRIES - 1 moves). One request is in work at a time; the next is taken once
// the result is registered, and an unread result holds the final step in S_DONE.
// Synchronous active-high reset empties the table, drops interrupt enable and loads the
// default ticks per second; the RAM contents are not cleared.
module multi_alarm_deadline_table_unit #(
   parameter int unsigned MAX_ENTRIES = madt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_now,
   input  logic [31:0] req_secs,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_compare_value,
   output logic [3:0]  rsp_fired_count,
   output logic        rsp_dropped,
   output logic [3:0]  rsp_pending_count,
   output logic        rsp_interrupt_enabled,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_ticks_per_second
);

   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned DW = madt_pkg::DEADLINE_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_TEST,
      S_MOVE,
      S_DONE
   } state_type;

   function automatic logic [3:0] sat4(input logic [CW-1:0] v);
      if (32'(v) > 32'd15) begin
         return 4'd15;
      end
      return 4'(v);
   endfunction

   state_type         state_ff, state_in;
   madt_pkg::kind_type kind_ff, kind_in;
   logic [DW-1:0]     now_ff, now_in;
   logic [31:0]       secs_ff, secs_in;
   logic [31:0]       tps_ff, tps_in;
   logic [DW-1:0]     prod_ff, prod_in;
   logic [DW-1:0]     min_ff, min_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     fired_ff, fired_in;
   logic              dropped_ff, dropped_in;
   logic              enable_ff, enable_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]     rsp_compare_ff, rsp_compare_in;
   logic [3:0]        rsp_fired_ff, rsp_fired_in;
   logic              rsp_dropped_ff, rsp_dropped_in;
   logic [3:0]        rsp_pending_ff, rsp_pending_in;
   logic              rsp_enable_ff, rsp_enable_in;

   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   logic [DW-1:0]     ram_wr_data;
   logic              ram_rd_en;
   logic [IW-1:0]     ram_rd_addr;
   logic [DW-1:0]     ram_rd_data;

   logic [CW-1:0]     count_dec;
   logic [CW-1:0]     k_next;
   logic [DW-1:0]     new_deadline;
   logic              expired;

   assign count_dec    = count_ff - CW'(1);
   assign k_next       = k_ff + CW'(1);
   assign new_deadline = now_ff + prod_ff;
   assign expired      = (ram_rd_data <= now_ff);

   madt_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ENTRIES)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      now_in         = now_ff;
      secs_in        = secs_ff;
      tps_in         = tps_ff;
      prod_in        = prod_ff;
      min_in         = min_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      fired_in       = fired_ff;
      dropped_in     = dropped_ff;
      enable_in      = enable_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_compare_in = rsp_compare_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_pending_in = rsp_pending_ff;
      rsp_enable_in  = rsp_enable_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = k_ff[IW-1:0];
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = k_ff[IW-1:0];

      if (csr_valid) begin
         tps_in = csr_ticks_per_second;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = madt_pkg::kind_type'(req_kind);
               now_in     = req_now;
               secs_in    = req_secs;
               fired_in   = '0;
               dropped_in = 1'b0;
               unique case (madt_pkg::kind_type'(req_kind))
                  madt_pkg::KIND_CLEAR: begin
                     count_in  = '0;
                     enable_in = 1'b1;
                     min_in    = madt_pkg::NO_DEADLINE;
                     state_in  = S_DONE;
                  end
                  madt_pkg::KIND_DISABLE: begin
                     enable_in = 1'b0;
                     state_in  = S_DONE;
                  end
                  madt_pkg::KIND_SET: begin
                     if (32'(count_ff) < MAX_ENTRIES) begin
                        state_in = S_MUL;
                     end else begin
                        dropped_in = 1'b1;
                        state_in   = S_DONE;
                     end
                  end
                  madt_pkg::KIND_SERVICE: begin
                     // Survivors are final once passed, so the minimum builds up
                     // during the scan itself.
                     k_in   = '0;
                     min_in = madt_pkg::NO_DEADLINE;
                     if (count_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_TEST;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_MUL: begin
            prod_in  = DW'(secs_ff) * DW'(tps_ff);
            state_in = S_ADD;
         end

         S_ADD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_ff[IW-1:0];
            ram_wr_data = new_deadline;
            count_in    = count_ff + CW'(1);
            if (new_deadline < min_ff) begin
               min_in = new_deadline;
            end
            state_in = S_DONE;
         end

         S_TEST: begin
            if (expired) begin
               fired_in = fired_ff + CW'(1);
               count_in = count_dec;
               if (k_ff == count_dec) begin
                  state_in = S_DONE;
               end else begin
                  // Fetch the last entry to fill the freed slot.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = count_dec[IW-1:0];
                  state_in    = S_MOVE;
               end
            end else begin
               if (ram_rd_data < min_ff) begin
                  min_in = ram_rd_data;
               end
               k_in = k_next;
               if (k_next < count_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = k_next[IW-1:0];
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_MOVE: begin
            // The moved entry stays on the read port and is tested next.
            ram_wr_en   = 1'b1;
            ram_wr_addr = k_ff[IW-1:0];
            ram_wr_data = ram_rd_data;
            state_in    = S_TEST;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_compare_in = (count_ff == '0) ? madt_pkg::NO_DEADLINE : min_ff;
               rsp_fired_in   = sat4(fired_ff);
               rsp_dropped_in = dropped_ff;
               rsp_pending_in = sat4(count_ff);
               rsp_enable_in  = enable_ff;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tps_ff       <= madt_pkg::TPS_RESET;
         min_ff       <= madt_pkg::NO_DEADLINE;
         count_ff     <= '0;
         k_ff         <= '0;
         fired_ff     <= '0;
         dropped_ff   <= 1'b0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         min_ff       <= min_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         fired_ff     <= fired_in;
         dropped_ff   <= dropped_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      now_ff         <= now_in;
      secs_ff        <= secs_in;
      prod_ff        <= prod_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_enable_ff  <= rsp_enable_in;
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_compare_value     = rsp_compare_ff;
   assign rsp_fired_count       = rsp_fired_ff;
   assign rsp_dropped           = rsp_dropped_ff;
   assign rsp_pending_count     = rsp_pending_ff;
   assign rsp_interrupt_enabled = rsp_enable_ff;

endmodule
